// ----- sv/cfbsa_pkg.sv -----
package cfbsa_pkg;

  localparam int unsigned IdW   = 29;
  localparam int unsigned WordW = 32;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  localparam logic [1:0] MODE_LIST16 = 2'd0;
  localparam logic [1:0] MODE_MASK16 = 2'd1;
  localparam logic [1:0] MODE_LIST32 = 2'd2;
  localparam logic [1:0] MODE_MASK32 = 2'd3;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  localparam logic [1:0] CFG_PATTERN_FIRST  = 2'd0;
  localparam logic [1:0] CFG_PATTERN_SECOND = 2'd1;

  localparam logic [31:0] LO_HALF    = 32'h0000_FFFF;
  localparam logic [31:0] HI_HALF    = 32'hFFFF_0000;
  localparam int unsigned STD16_SHIFT = 5;
  localparam logic [15:0] STD16_MASK = 16'hFFE0;
  localparam int unsigned STD32_SHIFT = 21;
  localparam logic [31:0] STD32_MASK = 32'hFFE0_0000;
  localparam int unsigned EXT32_SHIFT = 3;
  localparam logic [31:0] EXT32_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] EXT32_IDE  = 32'h0000_0008;
  localparam logic [31:0] EXT32_RTR  = 32'h0000_0004;
  localparam logic [15:0] ID16_RTR   = 16'h0020;

  typedef struct packed {
    logic           cmd;
    logic [3:0]     bank_index;
    logic [1:0]     filter_mode;
    logic           extended_id;
    logic           remote_frame;
    logic [IdW-1:0] identifier;
    logic [IdW-1:0] id_mask;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       slot;
    logic [WordW-1:0] word_first;
    logic [WordW-1:0] word_second;
  } out_t;

  typedef struct packed {
    out_t res;
    logic wr_en;
  } step_t;

  function automatic logic [15:0] pack16(logic [IdW-1:0] val, logic rtr);
    logic [15:0] e;
    e = (16'(val) << STD16_SHIFT) & STD16_MASK;
    if (rtr) e = e | ID16_RTR;
    return e;
  endfunction

  function automatic logic [31:0] pack32(logic [IdW-1:0] val, logic ext, logic rtr);
    logic [31:0] w;
    if (!ext) begin
      w = (32'(val) << STD32_SHIFT) & STD32_MASK;
    end else begin
      w = EXT32_IDE | ((32'(val) << EXT32_SHIFT) & EXT32_MASK);
      if (rtr) w = w | EXT32_RTR;
    end
    return w;
  endfunction

endpackage

// ----- sv/cfbsa_core.sv -----
module cfbsa_core
  import cfbsa_pkg::*;
(
  input  in_t         req_i,
  input  logic        in_range_i,
  input  logic [31:0] w0_i,
  input  logic [31:0] w1_i,
  input  logic [31:0] pat_first_i,
  input  logic [31:0] pat_second_i,
  output step_t       step_o
);

  logic        found;
  logic [1:0]  fslot;
  logic [15:0] e16;
  logic [15:0] m16;
  logic [31:0] p_id;
  logic [31:0] p_mask;
  logic [31:0] n0;
  logic [31:0] n1;

  assign e16    = pack16(req_i.identifier, req_i.remote_frame);
  assign m16    = pack16(req_i.id_mask, 1'b0);
  assign p_id   = pack32(req_i.identifier, req_i.extended_id, req_i.remote_frame);
  assign p_mask = pack32(req_i.id_mask, req_i.extended_id, req_i.remote_frame);

  always_comb begin
    found = 1'b0;
    fslot = SLOT_0;
    case (req_i.filter_mode)
      MODE_LIST16: begin
        if ((w0_i & LO_HALF) == (pat_first_i & LO_HALF)) begin
          found = 1'b1; fslot = SLOT_0;
        end else if ((w0_i & HI_HALF) == (pat_first_i & HI_HALF)) begin
          found = 1'b1; fslot = SLOT_1;
        end else if ((w1_i & LO_HALF) == (pat_second_i & LO_HALF)) begin
          found = 1'b1; fslot = SLOT_2;
        end else if ((w1_i & HI_HALF) == (pat_second_i & HI_HALF)) begin
          found = 1'b1; fslot = SLOT_3;
        end
      end
      MODE_MASK16, MODE_LIST32: begin
        if (w0_i == pat_first_i) begin
          found = 1'b1; fslot = SLOT_0;
        end else if (w1_i == pat_second_i) begin
          found = 1'b1; fslot = SLOT_1;
        end
      end
      default: begin
        found = (w0_i == pat_first_i) && (w1_i == pat_second_i);
      end
    endcase
  end

  always_comb begin
    n0 = w0_i;
    n1 = w1_i;
    case (req_i.filter_mode)
      MODE_LIST16: begin
        case (fslot)
          SLOT_0:  n0 = {w0_i[31:16], e16};
          SLOT_1:  n0 = {e16, w0_i[15:0]};
          SLOT_2:  n1 = {w1_i[31:16], e16};
          default: n1 = {e16, w1_i[15:0]};
        endcase
      end
      MODE_MASK16: begin
        if (fslot == SLOT_0) n0 = {m16, e16};
        else n1 = {m16, e16};
      end
      MODE_LIST32: begin
        if (fslot == SLOT_0) n0 = p_id;
        else n1 = p_id;
      end
      default: begin
        n0 = p_id;
        n1 = p_mask;
      end
    endcase
  end

  always_comb begin
    step_o                 = '0;
    step_o.res.slot        = SLOT_0;
    if (!in_range_i) begin
      step_o.res.status = (req_i.cmd == CMD_ADD) ? ST_FULL : ST_CLEARED;
    end else if (req_i.cmd == CMD_CLEAR) begin
      step_o.res.status      = ST_CLEARED;
      step_o.res.word_first  = pat_first_i;
      step_o.res.word_second = pat_second_i;
      step_o.wr_en           = 1'b1;
    end else begin
      step_o.res.word_first  = w0_i;
      step_o.res.word_second = w1_i;
      if (!found) begin
        step_o.res.status = ST_FULL;
      end else if (req_i.extended_id &&
                   (req_i.filter_mode == MODE_LIST16 || req_i.filter_mode == MODE_MASK16)) begin
        step_o.res.status = ST_REFUSED;
      end else begin
        step_o.res.status      = ST_PLACED;
        step_o.res.slot        = fslot;
        step_o.res.word_first  = n0;
        step_o.res.word_second = n1;
        step_o.wr_en           = 1'b1;
      end
    end
  end

endmodule

// ----- sv/can_filter_bank_slot_allocator_unit.sv -----
// An accepted transaction and its bank entry read are registered; the result goes to
// the output register once it is free. One transaction at a time: input stalls
// over the bank entry's read-modify-write (read at accept, write back at retire).
// Reset: asynchronous, active low; clears control state, both empty patterns and the
// per-bank valid bits, so every bank reads as zero until written. No clearing pass.
module can_filter_bank_slot_allocator_unit
  import cfbsa_pkg::*;
#(
  parameter int unsigned BANKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  localparam int unsigned BankAw = (BANKS > 1) ? $clog2(BANKS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  logic [31:0]       pat_first_q;
  logic [31:0]       pat_second_q;
  in_t               req_q;
  logic              in_range_q;
  logic [BankAw-1:0] addr_q;
  logic [63:0]       bank_mem_q [BANKS];
  logic [BANKS-1:0]  bank_vld_q;
  logic [63:0]       rd_word_q;
  logic              rd_vld_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic              in_accept;
  logic              in_range;
  logic [BankAw-1:0] in_addr;
  logic              advance;
  logic [31:0]       w0;
  logic [31:0]       w1;
  step_t             step;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = (32'(in_data_i.bank_index) < 32'(BANKS));
  assign in_addr     = BankAw'(in_data_i.bank_index);
  assign advance     = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign w0          = rd_vld_q ? rd_word_q[31:0]  : '0;
  assign w1          = rd_vld_q ? rd_word_q[63:32] : '0;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_first_q  <= '0;
      pat_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PATTERN_FIRST[0]) pat_first_q <= cfg_data_i;
      else pat_second_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = S_EXEC;
      S_EXEC:  if (advance) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bank_vld_q  <= '0;
    end else begin
      state_q <= state_d;
      if (advance) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (advance && step.wr_en) bank_vld_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= in_data_i;
      in_range_q <= in_range;
      addr_q     <= in_addr;
    end
    if (advance) out_data_q <= step.res;
  end

  // bank memory: one read at accept, one write back when a clear or placement retires
  always_ff @(posedge clk_i) begin
    if (in_accept && in_range) begin
      rd_word_q <= bank_mem_q[in_addr];
    end
    if (advance && step.wr_en) begin
      bank_mem_q[addr_q] <= {step.res.word_second, step.res.word_first};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (in_accept) begin
      rd_vld_q <= in_range && bank_vld_q[in_addr];
    end
  end

  cfbsa_core u_core (
    .req_i        (req_q),
    .in_range_i   (in_range_q),
    .w0_i         (w0),
    .w1_i         (w1),
    .pat_first_i  (pat_first_q),
    .pat_second_i (pat_second_q),
    .step_o       (step)
  );

endmodule

// ----- sv/cfbsa_checker.sv -----
module cfbsa_checker
  import cfbsa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second transaction taken while one is in flight");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing two cycles after accept");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_PLACED) |-> out_data_o.slot == SLOT_0)
    else $error("nonzero slot on a result that did not place");

endmodule

bind can_filter_bank_slot_allocator_unit cfbsa_checker u_cfbsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/can_filter_bank_slot_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module can_filter_bank_slot_allocator_unit_tb;
  import cfbsa_pkg::*;

  localparam int NUM_BANKS = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQS = 180;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  logic [31:0] bank_w0 [NUM_BANKS];
  logic [31:0] bank_w1 [NUM_BANKS];
  logic [31:0] pat_first = '0;
  logic [31:0] pat_second = '0;

  out_t     pending_results [$];
  dir_row_t dir_rows [$];
  out_t     want;
  int       mismatch_count = 0;
  int       requests_sent = 0;
  int       results_checked = 0;
  int       status_seen [4] = '{0, 0, 0, 0};
  int       pattern_writes = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  bit       hold_req = 1'b0;
  bit       held_long = 1'b0;

  can_filter_bank_slot_allocator_unit #(.BANKS(NUM_BANKS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] word32(logic [28:0] val, logic ext, logic rtr);
    if (!ext) return {val[10:0], 21'b0};
    return {val[28:1], 1'b1, rtr, 2'b00};
  endfunction

  // updates the bank table and returns the result of one transaction
  function automatic out_t predict_bank(in_t req);
    out_t        res;
    logic [31:0] w0, w1;
    logic [15:0] e16, m16;
    logic        found;
    logic [1:0]  slot;
    res = '0;
    found = 1'b0;
    slot = SLOT_0;
    if (int'(req.bank_index) >= NUM_BANKS) begin
      res.status = (req.cmd == CMD_ADD) ? ST_FULL : ST_CLEARED;
      return res;
    end
    if (req.cmd == CMD_CLEAR) begin
      bank_w0[req.bank_index] = pat_first;
      bank_w1[req.bank_index] = pat_second;
      res.status = ST_CLEARED;
      res.word_first = pat_first;
      res.word_second = pat_second;
      return res;
    end
    w0 = bank_w0[req.bank_index];
    w1 = bank_w1[req.bank_index];
    case (req.filter_mode)
      MODE_LIST16: begin
        if (w0[15:0] == pat_first[15:0]) begin
          found = 1'b1; slot = SLOT_0;
        end else if (w0[31:16] == pat_first[31:16]) begin
          found = 1'b1; slot = SLOT_1;
        end else if (w1[15:0] == pat_second[15:0]) begin
          found = 1'b1; slot = SLOT_2;
        end else if (w1[31:16] == pat_second[31:16]) begin
          found = 1'b1; slot = SLOT_3;
        end
      end
      MODE_MASK16, MODE_LIST32: begin
        if (w0 == pat_first) begin
          found = 1'b1; slot = SLOT_0;
        end else if (w1 == pat_second) begin
          found = 1'b1; slot = SLOT_1;
        end
      end
      default: begin
        found = (w0 == pat_first) && (w1 == pat_second);
      end
    endcase
    res.word_first = w0;
    res.word_second = w1;
    if (!found) begin
      res.status = ST_FULL;
      return res;
    end
    if (req.extended_id && (req.filter_mode == MODE_LIST16 ||
                            req.filter_mode == MODE_MASK16)) begin
      res.status = ST_REFUSED;
      return res;
    end
    e16 = {req.identifier[10:0], 5'b0};
    e16[5] = e16[5] | req.remote_frame;
    m16 = {req.id_mask[10:0], 5'b0};
    case (req.filter_mode)
      MODE_LIST16: begin
        case (slot)
          SLOT_0: w0[15:0] = e16;
          SLOT_1: w0[31:16] = e16;
          SLOT_2: w1[15:0] = e16;
          default: w1[31:16] = e16;
        endcase
      end
      MODE_MASK16: begin
        if (slot == SLOT_0) w0 = {m16, e16};
        else w1 = {m16, e16};
      end
      MODE_LIST32: begin
        if (slot == SLOT_0) w0 = word32(req.identifier, req.extended_id, req.remote_frame);
        else w1 = word32(req.identifier, req.extended_id, req.remote_frame);
      end
      default: begin
        w0 = word32(req.identifier, req.extended_id, req.remote_frame);
        w1 = word32(req.id_mask, req.extended_id, req.remote_frame);
      end
    endcase
    bank_w0[req.bank_index] = w0;
    bank_w1[req.bank_index] = w1;
    res.status = ST_PLACED;
    res.slot = slot;
    res.word_first = w0;
    res.word_second = w1;
    return res;
  endfunction

  function automatic in_t mk_req(logic cmd, logic [3:0] bank, logic [1:0] mode,
                                 logic ext, logic rtr, logic [28:0] ident,
                                 logic [28:0] msk);
    in_t r;
    r.cmd = cmd;
    r.bank_index = bank;
    r.filter_mode = mode;
    r.extended_id = ext;
    r.remote_frame = rtr;
    r.identifier = ident;
    r.id_mask = msk;
    return r;
  endfunction

  function automatic out_t mk_res(logic [1:0] st, logic [1:0] slot, logic [31:0] w0,
                                  logic [31:0] w1);
    out_t r;
    r.status = st;
    r.slot = slot;
    r.word_first = w0;
    r.word_second = w1;
    return r;
  endfunction

  function automatic logic [28:0] rand_ident();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 29'h1FFF_FFFF;
      2: return 29'($urandom_range(0, 2047));
      default: return 29'($urandom);
    endcase
  endfunction

  function automatic in_t rand_req();
    return mk_req(($urandom_range(0, 3) != 0), 4'($urandom), 2'($urandom), 1'($urandom),
                  1'($urandom), rand_ident(), rand_ident());
  endfunction

  task automatic send_req(in_t req, bit typed, out_t typed_res);
    out_t res;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_bank(req);
    pending_results.push_back(typed ? typed_res : res);
    requests_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_patterns(logic [31:0] first, logic [31:0] second);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_PATTERN_FIRST[0];
    cfg_data_i <= first;
    pat_first = first;
    @(negedge clk_i);
    cfg_index_i <= CFG_PATTERN_SECOND[0];
    cfg_data_i <= second;
    pat_second = second;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pattern_writes++;
  endtask

  task automatic run_phase(logic [31:0] first, logic [31:0] second, bit long_hold);
    int         phase_count;
    int         adds;
    logic [3:0] bank;
    logic [1:0] mode;
    logic       ext;
    phase_count = 0;
    settle();
    write_patterns(first, second);
    if (long_hold) hold_req = 1'b1;
    while (phase_count < PHASE_REQS) begin
      if ($urandom_range(0, 99) < 15) begin
        send_req(rand_req(), 1'b0, '0);
        phase_count++;
      end else begin
        bank = 4'($urandom_range(0, NUM_BANKS - 1));
        if ($urandom_range(0, 99) < 80) begin
          send_req(mk_req(CMD_CLEAR, bank, 2'($urandom), 1'($urandom), 1'($urandom),
                          rand_ident(), rand_ident()), 1'b0, '0);
          phase_count++;
        end
        mode = 2'($urandom);
        adds = $urandom_range(1, 5);
        repeat (adds) begin
          if ($urandom_range(0, 4) == 0) mode = 2'($urandom);
          if (mode == MODE_LIST32 || mode == MODE_MASK32) ext = 1'($urandom);
          else ext = ($urandom_range(0, 9) == 0);
          send_req(mk_req(CMD_ADD, bank, mode, ext, 1'($urandom), rand_ident(),
                          rand_ident()), 1'b0, '0);
          phase_count++;
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %h, got %h", name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_data_o.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("slot", 32'(want.slot), 32'(out_data_o.slot));
        check_field("word_first", want.word_first, out_data_o.word_first);
        check_field("word_second", want.word_second, out_data_o.word_second);
        status_seen[out_data_o.status]++;
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output stall pattern; one long hold-off to back the block up
  initial begin
    int pct;
    int left;
    pct = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (150) @(negedge clk_i);
        hold_req = 1'b0;
        held_long = 1'b1;
      end
      if (left == 0) begin
        left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 80;
        endcase
      end
      left--;
      out_stall_i <= ($urandom_range(0, 99) < pct);
    end
  end

  initial begin
    foreach (bank_w0[i]) begin
      bank_w0[i] = '0;
      bank_w1[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b0, 1'b1, 29'h7FF, 29'h0),
                         1'b1, mk_res(ST_PLACED, SLOT_0, 32'h0000_FFE0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b0, 1'b0, 29'h555, 29'h0),
                         1'b1, mk_res(ST_PLACED, SLOT_1, 32'hAAA0_FFE0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b1, 1'b1, 29'h1FFF_FFFF,
                                29'h0), 1'b1,
                         mk_res(ST_REFUSED, SLOT_0, 32'hAAA0_FFE0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b0, 1'b0, 29'h001, 29'h0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b0, 1'b1, 29'h7FF, 29'h0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd0, MODE_LIST16, 1'b1, 1'b0, 29'h123_4567,
                                29'h0), 1'b1,
                         mk_res(ST_FULL, SLOT_0, 32'hAAA0_FFE0, 32'hFFE0_0020)});
    dir_rows.push_back('{mk_req(CMD_CLEAR, 4'd0, MODE_LIST16, 1'b0, 1'b0, 29'h0, 29'h0),
                         1'b1, mk_res(ST_CLEARED, SLOT_0, 32'h0, 32'h0)});
    // high identifier bits drop out, so the entry matches the empty pattern again
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd5, MODE_LIST16, 1'b0, 1'b0, 29'h1FFF_F800,
                                29'h0), 1'b1,
                         mk_res(ST_PLACED, SLOT_0, 32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd5, MODE_LIST16, 1'b0, 1'b0, 29'h1FFF_F800,
                                29'h0), 1'b1,
                         mk_res(ST_PLACED, SLOT_0, 32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd1, MODE_MASK16, 1'b0, 1'b1, 29'h7FF, 29'h7FF),
                         1'b1, mk_res(ST_PLACED, SLOT_0, 32'hFFE0_FFE0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd1, MODE_MASK16, 1'b0, 1'b0, 29'h0, 29'h0),
                         1'b1, mk_res(ST_PLACED, SLOT_1, 32'hFFE0_FFE0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd1, MODE_MASK16, 1'b0, 1'b1, 29'h123, 29'h456),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd1, MODE_MASK16, 1'b0, 1'b0, 29'h3C, 29'h5A),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd2, MODE_LIST32, 1'b0, 1'b1, 29'h7FF, 29'h0),
                         1'b1, mk_res(ST_PLACED, SLOT_0, 32'hFFE0_0000, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd2, MODE_LIST32, 1'b1, 1'b1, 29'h1FFF_FFFF,
                                29'h0), 1'b1,
                         mk_res(ST_PLACED, SLOT_1, 32'hFFE0_0000, 32'hFFFF_FFFC)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd2, MODE_LIST32, 1'b1, 1'b0, 29'h0, 29'h0),
                         1'b1, mk_res(ST_FULL, SLOT_0, 32'hFFE0_0000, 32'hFFFF_FFFC)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd3, MODE_MASK32, 1'b1, 1'b0, 29'h0,
                                29'h1FFF_FFFF), 1'b1,
                         mk_res(ST_PLACED, SLOT_0, 32'h0000_0008, 32'hFFFF_FFF8)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd3, MODE_MASK32, 1'b0, 1'b0, 29'h1, 29'h1),
                         1'b1, mk_res(ST_FULL, SLOT_0, 32'h0000_0008, 32'hFFFF_FFF8)});
    dir_rows.push_back('{mk_req(CMD_CLEAR, 4'd3, MODE_MASK32, 1'b1, 1'b1, 29'h1FFF_FFFF,
                                29'h1FFF_FFFF), 1'b1,
                         mk_res(ST_CLEARED, SLOT_0, 32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd3, MODE_MASK32, 1'b0, 1'b1, 29'h7FF, 29'h555),
                         1'b1, mk_res(ST_PLACED, SLOT_0, 32'hFFE0_0000, 32'hAAA0_0000)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd15, MODE_LIST32, 1'b1, 1'b0, 29'h0, 29'h0),
                         1'b1, mk_res(ST_PLACED, SLOT_0, 32'h0000_0008, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd15, MODE_MASK16, 1'b1, 1'b1, 29'hA_BCDE,
                                29'h0), 1'b1,
                         mk_res(ST_REFUSED, SLOT_0, 32'h0000_0008, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd15, MODE_MASK32, 1'b1, 1'b1, 29'h155_5555,
                                29'h0AA_AAAA), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_ADD, 4'd4, MODE_MASK32, 1'b1, 1'b1, 29'h1FFF_FFFF,
                                29'h0), 1'b0, '0});

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_phase($urandom, $urandom, 1'b1);
    run_phase(32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    run_phase(32'h0, 32'h0, 1'b0);
    run_phase($urandom, $urandom, 1'b0);
    settle();

    $display("%0d requests, %0d results checked, %0d pattern settings, long hold %0d",
             requests_sent, results_checked, pattern_writes, held_long);
    $display("placed %0d, full %0d, refused %0d, cleared %0d",
             status_seen[ST_PLACED], status_seen[ST_FULL], status_seen[ST_REFUSED],
             status_seen[ST_CLEARED]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
